### design/vdib_pkg.sv
// vdib_pkg: shared types, constants and control codes of the vertex deduplication index builder
`default_nettype none
package vdib_pkg;

  localparam int POSITION_DEPTH = 1024;
  localparam int VERTEX_DEPTH   = 1024;

  localparam int PAW = $clog2(POSITION_DEPTH);
  localparam int VAW = $clog2(VERTEX_DEPTH);
  localparam int VCW = $clog2(VERTEX_DEPTH + 1);

  localparam int CW   = 32;
  localparam int SW   = 10;
  localparam int RW   = 11;
  localparam int VIW  = 10;
  localparam int PW   = 3 * CW;
  localparam int TW   = 2;
  localparam int VW   = PW + TW;

  localparam logic [CW-1:0] Z_SIGN = 32'h8000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FACE = 1'b1;

  localparam logic [TW-1:0] CORNER_FIRST = 2'd0;
  localparam logic [TW-1:0] CORNER_MID   = 2'd1;
  localparam logic [TW-1:0] CORNER_LAST  = 2'd2;

  typedef struct packed {
    logic          operation;
    logic [SW-1:0] position_slot;
    logic [CW-1:0] coord_x;
    logic [CW-1:0] coord_y;
    logic [CW-1:0] coord_z;
    logic [RW-1:0] face_ref_a;
    logic [RW-1:0] face_ref_b;
    logic [RW-1:0] face_ref_c;
  } in_item_t;

  typedef struct packed {
    logic [VIW-1:0] vertex_index;
    logic           newly_added;
    logic [TW-1:0]  corner_number;
    logic           last_of_face;
    logic           table_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS_RD,
    S_POS_WAIT,
    S_SCAN,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic face_start;
    logic pos_rd;
    logic pos_cap;
    logic scan_start;
    logic scan_run;
    logic resolve;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic out_free;
    logic last_corner;
  } sts_t;

endpackage
`default_nettype wire

### design/vdib_ram.sv
// vdib_ram: generic simple dual port ram with registered read
`default_nettype none
module vdib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/vdib_ctrl.sv
// vdib_ctrl: sequencer for loads and the per-corner fetch, scan and resolve steps
`default_nettype none
module vdib_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_stall,
  input  wire vdib_pkg::sts_t sts,
  output vdib_pkg::cmd_t     cmd
);

  vdib_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdib_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdib_pkg::S_IDLE: begin
        if (in_valid && in_op == vdib_pkg::OP_FACE) begin
          state_nxt = vdib_pkg::S_POS_RD;
        end
      end
      vdib_pkg::S_POS_RD: begin
        state_nxt = vdib_pkg::S_POS_WAIT;
      end
      vdib_pkg::S_POS_WAIT: begin
        state_nxt = vdib_pkg::S_SCAN;
      end
      vdib_pkg::S_SCAN: begin
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = vdib_pkg::S_RESOLVE;
        end
      end
      vdib_pkg::S_RESOLVE: begin
        if (sts.out_free) begin
          state_nxt = sts.last_corner ? vdib_pkg::S_IDLE : vdib_pkg::S_POS_RD;
        end
      end
      default: state_nxt = vdib_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      vdib_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_wr    = in_valid && in_op == vdib_pkg::OP_LOAD;
        cmd.face_start = in_valid && in_op == vdib_pkg::OP_FACE;
      end
      vdib_pkg::S_POS_RD: begin
        cmd.pos_rd = 1'b1;
      end
      vdib_pkg::S_POS_WAIT: begin
        cmd.pos_cap    = 1'b1;
        cmd.scan_start = 1'b1;
      end
      vdib_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      vdib_pkg::S_RESOLVE: begin
        cmd.resolve = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/vdib_datapath.sv
// vdib_datapath: position and vertex stores, search key, scan counter and result register
`default_nettype none
module vdib_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vdib_pkg::cmd_t      cmd,
  output vdib_pkg::sts_t           sts,
  input  wire vdib_pkg::in_item_t  in_data,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output vdib_pkg::out_item_t      out_data
);

  logic [vdib_pkg::RW-1:0]  ref_a_r, ref_b_r, ref_c_r;
  logic [vdib_pkg::TW-1:0]  corner_r;
  logic [vdib_pkg::VCW-1:0] count_r, before_r, scan_addr_r;
  logic                     rd_vld_r, hit_r, key_zero_r, out_valid_r;
  logic [vdib_pkg::VAW-1:0] hit_idx_r;
  logic [vdib_pkg::PW-1:0]  key_r;
  vdib_pkg::out_item_t      out_data_r;

  logic [vdib_pkg::RW-1:0]  cur_ref;
  logic                     ref_bad;
  logic                     pos_wr_en;
  logic [vdib_pkg::PAW-1:0] pos_wr_addr, pos_rd_addr;
  logic [vdib_pkg::PW-1:0]  pos_wr_data, pos_rd_data;
  logic                     scan_issue, match, full, append, out_free;
  logic [vdib_pkg::VW-1:0]  vtx_rd_data, vtx_key;
  logic [vdib_pkg::VCW-1:0] res_idx;

  always_comb begin
    case (corner_r)
      vdib_pkg::CORNER_FIRST: cur_ref = ref_a_r;
      vdib_pkg::CORNER_MID:   cur_ref = ref_b_r;
      default:                cur_ref = ref_c_r;
    endcase
  end

  assign ref_bad     = (cur_ref == '0) || (32'(cur_ref) > 32'(vdib_pkg::POSITION_DEPTH));
  assign pos_rd_addr = vdib_pkg::PAW'(cur_ref - vdib_pkg::RW'(1));

  // load transfer: z stored with its sign bit inverted
  assign pos_wr_en   = cmd.load_wr &&
                       (32'(in_data.position_slot) < 32'(vdib_pkg::POSITION_DEPTH));
  assign pos_wr_addr = vdib_pkg::PAW'(in_data.position_slot);
  assign pos_wr_data = {in_data.coord_z ^ vdib_pkg::Z_SIGN, in_data.coord_y, in_data.coord_x};

  vdib_ram #(
    .WIDTH (vdib_pkg::PW),
    .DEPTH (vdib_pkg::POSITION_DEPTH)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_wr_en),
    .wr_addr (pos_wr_addr),
    .wr_data (pos_wr_data),
    .rd_en   (cmd.pos_rd),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  assign vtx_key    = {corner_r, key_r};
  assign scan_issue = cmd.scan_run && (scan_addr_r < before_r);
  assign match      = rd_vld_r && (vtx_rd_data == vtx_key);
  assign full       = 32'(count_r) >= 32'(vdib_pkg::VERTEX_DEPTH);
  assign append     = cmd.resolve && !hit_r && !full;

  vdib_ram #(
    .WIDTH (vdib_pkg::VW),
    .DEPTH (vdib_pkg::VERTEX_DEPTH)
  ) u_vtx_ram (
    .clk     (clk),
    .wr_en   (append),
    .wr_addr (count_r[vdib_pkg::VAW-1:0]),
    .wr_data (vtx_key),
    .rd_en   (scan_issue),
    .rd_addr (scan_addr_r[vdib_pkg::VAW-1:0]),
    .rd_data (vtx_rd_data)
  );

  always_comb begin
    if (hit_r) begin
      res_idx = vdib_pkg::VCW'(hit_idx_r);
    end else if (full) begin
      res_idx = '0;
    end else begin
      res_idx = count_r;
    end
  end

  assign out_free        = !out_valid_r || !out_stall;
  assign sts.scan_hit    = match;
  assign sts.scan_end    = !rd_vld_r && (scan_addr_r >= before_r);
  assign sts.out_free    = out_free;
  assign sts.last_corner = corner_r == vdib_pkg::CORNER_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      corner_r    <= vdib_pkg::CORNER_FIRST;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.face_start) begin
        corner_r <= vdib_pkg::CORNER_FIRST;
      end else if (cmd.resolve) begin
        corner_r <= corner_r + vdib_pkg::TW'(1);
      end
      if (append) begin
        count_r <= count_r + vdib_pkg::VCW'(1);
      end
      rd_vld_r <= scan_issue && !cmd.scan_start;
      if (cmd.scan_start) begin
        hit_r <= 1'b0;
      end else if (cmd.scan_run && match) begin
        hit_r <= 1'b1;
      end
      if (cmd.resolve) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.face_start) begin
      ref_a_r  <= in_data.face_ref_a;
      ref_b_r  <= in_data.face_ref_b;
      ref_c_r  <= in_data.face_ref_c;
      before_r <= count_r;
    end
    if (cmd.pos_rd) begin
      key_zero_r <= ref_bad;
    end
    if (cmd.pos_cap) begin
      key_r <= key_zero_r ? '0 : pos_rd_data;
    end
    if (cmd.scan_start) begin
      scan_addr_r <= '0;
    end else if (scan_issue) begin
      scan_addr_r <= scan_addr_r + vdib_pkg::VCW'(1);
    end
    // first hit is the lowest index, scan stops there
    if (cmd.scan_run && match && !hit_r) begin
      hit_idx_r <= vdib_pkg::VAW'(scan_addr_r - vdib_pkg::VCW'(1));
    end
    if (cmd.resolve) begin
      out_data_r.vertex_index   <= vdib_pkg::VIW'(res_idx);
      out_data_r.newly_added    <= append;
      out_data_r.corner_number  <= corner_r;
      out_data_r.last_of_face   <= corner_r == vdib_pkg::CORNER_LAST;
      out_data_r.table_overflow <= !hit_r && full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### design/vertex_dedup_index_builder_unit.sv
// vertex_dedup_index_builder_unit: top level of the vertex deduplication index builder
//
//   channel  | ports                        | moves
//   ---------+------------------------------+------------------------------------
//   input    | in_valid, in_stall, in_data  | one load or face item per transfer
//   result   | out_valid, out_stall, out_data | one corner result per transfer
//
// a load is written straight into the position store; a face is handled as three corners,
// each with a scan that reads the vertex store one entry a cycle, up to VERTEX_DEPTH
// reset clears the vertex count and control state; store contents are undefined until written
// a stalled result holds in the output register; the next corner resolves once it is taken
`default_nettype none
module vertex_dedup_index_builder_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vdib_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vdib_pkg::out_item_t      out_data
);

  vdib_pkg::cmd_t cmd;
  vdib_pkg::sts_t sts;

  vdib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vdib_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### test/vertex_dedup_index_builder_unit_test.sv
// vertex_dedup_index_builder_unit_test: self-checking bench for the vertex dedup index builder
`timescale 1ns / 1ps
module vertex_dedup_index_builder_unit_test;

  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int ITEM_GOAL     = 450;
  localparam int DRAIN_CYCLES  = 3200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  vdib_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vdib_pkg::out_item_t out_data;

  vertex_dedup_index_builder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [2*vdib_pkg::CW-1:0] pos_xy_mem [vdib_pkg::POSITION_DEPTH];
  logic [vdib_pkg::CW-1:0]   pos_z_mem  [vdib_pkg::POSITION_DEPTH];
  logic [2*vdib_pkg::CW-1:0] vtx_xy_mem [vdib_pkg::VERTEX_DEPTH];
  logic [vdib_pkg::CW-1:0]   vtx_z_mem  [vdib_pkg::VERTEX_DEPTH];
  logic [vdib_pkg::TW-1:0]   vtx_tag_mem[vdib_pkg::VERTEX_DEPTH];
  int                        vtx_count = 0;

  vdib_pkg::in_item_t  items_to_send[$];
  vdib_pkg::out_item_t corner_results_due[$];
  vdib_pkg::out_item_t want_result;

  bit        slot_loaded [vdib_pkg::POSITION_DEPTH];
  int        loaded_slots[$];
  int        queued_total = 0;
  logic [vdib_pkg::RW-1:0] last_a, last_b, last_c;

  int  items_sent = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int expected_val, input int got_val);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, expected_val, got_val);
    mismatch_count++;
  endtask

  task automatic predict_corners(input vdib_pkg::in_item_t it);
    logic [vdib_pkg::RW-1:0]   refs [3];
    logic [2*vdib_pkg::CW-1:0] cxy  [3];
    logic [vdib_pkg::CW-1:0]   cz   [3];
    logic [vdib_pkg::TW-1:0]   tag;
    vdib_pkg::out_item_t       res;
    int                        prior_count;
    int                        idx;
    bit                        hit;
    refs[0] = it.face_ref_a;
    refs[1] = it.face_ref_b;
    refs[2] = it.face_ref_c;
    if (it.operation == vdib_pkg::OP_LOAD) begin
      pos_xy_mem[it.position_slot] = {it.coord_y, it.coord_x};
      pos_z_mem[it.position_slot]  = it.coord_z ^ vdib_pkg::Z_SIGN;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (refs[k] == 0 || refs[k] > vdib_pkg::POSITION_DEPTH) begin
          cxy[k] = '0;
          cz[k]  = '0;
        end else begin
          cxy[k] = pos_xy_mem[refs[k] - 1];
          cz[k]  = pos_z_mem[refs[k] - 1];
        end
      end
      prior_count = vtx_count;
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: tag = vdib_pkg::CORNER_FIRST;
          1: tag = vdib_pkg::CORNER_MID;
          default: tag = vdib_pkg::CORNER_LAST;
        endcase
        hit = 1'b0;
        idx = 0;
        // lowest matching entry of the table as it stood ahead of the face
        for (int n = 0; n < prior_count && !hit; n++) begin
          if (vtx_xy_mem[n] == cxy[k] && vtx_z_mem[n] == cz[k] && vtx_tag_mem[n] == tag) begin
            hit = 1'b1;
            idx = n;
          end
        end
        res = '0;
        res.corner_number = tag;
        res.last_of_face  = (k == 2);
        if (hit) begin
          res.vertex_index = vdib_pkg::VIW'(idx);
        end else if (vtx_count < vdib_pkg::VERTEX_DEPTH) begin
          vtx_xy_mem[vtx_count]  = cxy[k];
          vtx_z_mem[vtx_count]   = cz[k];
          vtx_tag_mem[vtx_count] = tag;
          res.vertex_index = vdib_pkg::VIW'(vtx_count);
          res.newly_added  = 1'b1;
          vtx_count++;
        end else begin
          res.table_overflow = 1'b1;
        end
        corner_results_due = {corner_results_due, res};
      end
    end
  endtask

  function automatic vdib_pkg::in_item_t random_item();
    vdib_pkg::in_item_t it;
    it.operation     = vdib_pkg::OP_LOAD;
    it.position_slot = vdib_pkg::SW'($urandom());
    it.coord_x       = $urandom();
    it.coord_y       = $urandom();
    it.coord_z       = $urandom();
    it.face_ref_a    = vdib_pkg::RW'($urandom());
    it.face_ref_b    = vdib_pkg::RW'($urandom());
    it.face_ref_c    = vdib_pkg::RW'($urandom());
    return it;
  endfunction

  function automatic logic [vdib_pkg::CW-1:0] coord_pick();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return vdib_pkg::Z_SIGN;
      2: return 32'h7f80_0000;
      3: return 32'hffff_ffff;
      4: return 32'h3f80_0000;
      default: return $urandom();
    endcase
  endfunction

  // only loaded slots or out-of-range references, never an unwritten slot
  function automatic logic [vdib_pkg::RW-1:0] pick_ref();
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1) == 0) return '0;
      return vdib_pkg::RW'($urandom_range(vdib_pkg::POSITION_DEPTH + 1, 2047));
    end
    return vdib_pkg::RW'(loaded_slots[$urandom_range(loaded_slots.size() - 1)] + 1);
  endfunction

  task automatic queue_item(input vdib_pkg::in_item_t it);
    while (items_to_send.size() > 3) @(negedge clk);
    items_to_send = {items_to_send, it};
    queued_total++;
  endtask

  task automatic load_item(input int slot, input logic [vdib_pkg::CW-1:0] x,
                           input logic [vdib_pkg::CW-1:0] y, input logic [vdib_pkg::CW-1:0] z);
    vdib_pkg::in_item_t it;
    it = random_item();
    it.operation     = vdib_pkg::OP_LOAD;
    it.position_slot = vdib_pkg::SW'(slot);
    it.coord_x       = x;
    it.coord_y       = y;
    it.coord_z       = z;
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots = {loaded_slots, slot};
    end
    queue_item(it);
  endtask

  task automatic face_item(input logic [vdib_pkg::RW-1:0] a, input logic [vdib_pkg::RW-1:0] b,
                           input logic [vdib_pkg::RW-1:0] c);
    vdib_pkg::in_item_t it;
    it = random_item();
    it.operation  = vdib_pkg::OP_FACE;
    it.face_ref_a = a;
    it.face_ref_b = b;
    it.face_ref_c = c;
    last_a = a;
    last_b = b;
    last_c = c;
    queue_item(it);
  endtask

  // stimulus
  initial begin
    int s0, s1, s2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, out-of-range references, negated zero, overwrite
    load_item(0, 32'h0, 32'h0, vdib_pkg::Z_SIGN);
    load_item(vdib_pkg::POSITION_DEPTH - 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    load_item(5, 32'h3f80_0000, 32'h0, 32'h0);
    face_item(11'd1, 11'd1024, 11'd6);
    face_item(11'd1, 11'd1024, 11'd6);
    face_item(11'd0, 11'd2047, 11'd1025);
    face_item(11'd6, 11'd1, 11'd1024);
    load_item(5, 32'h7f80_0000, 32'h7fc0_0000, 32'h0000_0001);
    face_item(11'd6, 11'd6, 11'd6);
    load_item(5, 32'h3f80_0000, 32'h0, 32'h0);
    face_item(11'd6, 11'd1024, 11'd1);
    load_item(682, 32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0001);
    load_item(341, 32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff);
    face_item(11'd683, 11'd342, 11'd683);
    face_item(11'd342, 11'd683, 11'd342);
    face_item(11'd2047, 11'd0, 11'd1024);
    face_item(11'd1025, 11'd1, 11'd0);

    // random: mostly rotated triples of fresh positions, the rest noise
    while (queued_total < ITEM_GOAL) begin
      if (vtx_count < vdib_pkg::VERTEX_DEPTH && $urandom_range(99) < 75) begin
        s0 = $urandom_range(vdib_pkg::POSITION_DEPTH - 1);
        s1 = $urandom_range(vdib_pkg::POSITION_DEPTH - 1);
        s2 = $urandom_range(vdib_pkg::POSITION_DEPTH - 1);
        load_item(s0, $urandom(), $urandom(), $urandom());
        load_item(s1, $urandom(), $urandom(), $urandom());
        load_item(s2, $urandom(), $urandom(), $urandom());
        face_item(vdib_pkg::RW'(s0 + 1), vdib_pkg::RW'(s1 + 1), vdib_pkg::RW'(s2 + 1));
        face_item(vdib_pkg::RW'(s1 + 1), vdib_pkg::RW'(s2 + 1), vdib_pkg::RW'(s0 + 1));
        face_item(vdib_pkg::RW'(s2 + 1), vdib_pkg::RW'(s0 + 1), vdib_pkg::RW'(s1 + 1));
      end else begin
        case ($urandom_range(3))
          0: load_item($urandom_range(vdib_pkg::POSITION_DEPTH - 1), coord_pick(), coord_pick(),
                       coord_pick());
          1: face_item(last_a, last_b, last_c);
          2: face_item(pick_ref(), pick_ref(), pick_ref());
          default: load_item($urandom_range(vdib_pkg::POSITION_DEPTH - 1), $urandom(),
                             $urandom(), $urandom());
        endcase
      end
    end

    while (items_to_send.size() != 0 || in_valid) @(negedge clk);
    while (corner_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_corners(in_data);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() != 0 &&
            ((items_sent >= 150 && items_sent < 250) || $urandom_range(99) >= 19)) begin
          in_data  <= items_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (corner_results_due.size() == 0) begin
          report_mismatch("unexpected result transfer", 0, int'(out_data));
        end else begin
          want_result = corner_results_due.pop_front();
          if (out_data.vertex_index !== want_result.vertex_index)
            report_mismatch("vertex_index", want_result.vertex_index, out_data.vertex_index);
          if (out_data.newly_added !== want_result.newly_added)
            report_mismatch("newly_added", want_result.newly_added, out_data.newly_added);
          if (out_data.corner_number !== want_result.corner_number)
            report_mismatch("corner_number", want_result.corner_number, out_data.corner_number);
          if (out_data.last_of_face !== want_result.last_of_face)
            report_mismatch("last_of_face", want_result.last_of_face, out_data.last_of_face);
          if (out_data.table_overflow !== want_result.table_overflow)
            report_mismatch("table_overflow", want_result.table_overflow,
                            out_data.table_overflow);
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(results_seen >= 300 && results_seen < 600) && ($urandom_range(99) < 19);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
